// ===== rtl/lttc_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the LFU/TTL cache table.
// Used by lttc_entry_ram and lfu_ttl_cache_table; no dependencies.
package lttc_pkg;

   localparam int TABLE_DEPTH_DEF = 16;

   localparam logic [4:0]  MAX_ITEMS_RST = 5'd16;
   localparam logic [31:0] TTL_TICKS_RST = 32'd3600;

   // configuration register indexes
   localparam logic [7:0] CSR_MAX_ITEMS = 8'd0;
   localparam logic [7:0] CSR_TTL_TICKS = 8'd1;

   typedef enum logic [1:0] {
      MODE_GET    = 2'd0,
      MODE_PUT    = 2'd1,
      MODE_REMOVE = 2'd2,
      MODE_CLEAR  = 2'd3
   } mode_type;

   typedef struct packed {
      logic [63:0] key;
      logic [31:0] value;
      logic [31:0] created;
      logic [31:0] last_use;
      logic [31:0] uses;
   } entry_type;

   function automatic logic [31:0] sat_inc32(input logic [31:0] v);
      return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
   endfunction

endpackage

// ===== rtl/lfu_ttl_cache_table.sv =====
`timescale 1ns / 1ps
// Top level of the LFU cache table with TTL expiry: sequencer, scan compare unit,
// valid bits, counters and result register. Depends on lttc_pkg and lttc_entry_ram.
//
//  channel | direction | handshake              | payload
//  req     | in        | req_tvalid/req_tready  | tuser: mode; tdata: key_tag, put_value, now
//  rsp     | out       | rsp_tvalid/rsp_tready  | tuser: hit; tdata: get_value, hit_total,
//          |           |                        |        miss_total, entries_used
//  csr     | in        | csr_valid/csr_ready    | csr_index, csr_data
//
// Get, put and remove scan every slot of the table; clear skips the scan.
// The cost is set by the single read port of the entry RAM, which is walked one
// slot per clock through one key compare and one use/age compare.
// Reset clears the valid bits and counters and restores the configuration defaults;
// entry RAM is not cleared. The result register holds while rsp_tready is low; the next request is taken
// meanwhile, and the sequencer waits before loading a new result.
module lfu_ttl_cache_table #(
   parameter int TABLE_DEPTH = lttc_pkg::TABLE_DEPTH_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [127:0] req_tdata,   // [63:0] key_tag, [95:64] put_value, [127:96] now
   input  logic [1:0]   req_tuser,   // [1:0] mode
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [103:0] rsp_tdata,   // [31:0] get_value, [63:32] hit_total,
                                     // [95:64] miss_total, [100:96] entries_used, rest 0
   output logic         rsp_tuser,   // [0] hit
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [7:0]   csr_index,
   input  logic [31:0]  csr_data
);
   import lttc_pkg::*;

   localparam int IW = $clog2(TABLE_DEPTH);
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam int MW = (CW > 5) ? CW : 5;
   localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_DEPTH - 1);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SCAN   = 4'b0010,
      ST_DECIDE = 4'b0100,
      ST_OUT    = 4'b1000
   } state_type;

   // control state
   state_type              state_ff, state_in;
   logic [4:0]             max_items_ff;
   logic [31:0]            ttl_ff;
   logic [TABLE_DEPTH-1:0] valid_ff, valid_in;
   logic [CW-1:0]          count_ff, count_in;
   logic [31:0]            hit_cnt_ff, hit_cnt_in;
   logic [31:0]            miss_cnt_ff, miss_cnt_in;
   logic                   issue_ff, issue_in;
   logic                   d_vld_ff, d_vld_in;
   logic                   rsp_tvalid_ff, rsp_tvalid_in;

   // payload state
   mode_type    op_mode_ff, op_mode_in;
   logic [63:0] op_key_ff, op_key_in;
   logic [31:0] op_val_ff, op_val_in;
   logic [31:0] op_now_ff, op_now_in;
   logic [IW-1:0] idx_ff, idx_in;
   logic [IW-1:0] d_idx_ff, d_idx_in;
   logic          found_ff, found_in;
   logic [IW-1:0] match_ff, match_in;
   entry_type     ment_ff, ment_in;
   logic          free_found_ff, free_found_in;
   logic [IW-1:0] free_ff, free_in;
   logic          vic_found_ff, vic_found_in;
   logic [IW-1:0] vic_ff, vic_in;
   logic [31:0]   vic_uses_ff, vic_uses_in;
   logic [31:0]   vic_last_ff, vic_last_in;
   logic          res_hit_ff, res_hit_in;
   logic [31:0]   res_gval_ff, res_gval_in;
   logic          rsp_hit_ff, rsp_hit_in;
   logic [31:0]   rsp_gval_ff, rsp_gval_in;
   logic [31:0]   rsp_hits_ff, rsp_hits_in;
   logic [31:0]   rsp_miss_ff, rsp_miss_in;
   logic [4:0]    rsp_used_ff, rsp_used_in;

   // RAM interface
   entry_type     rd_data;
   logic          wr_en;
   logic [IW-1:0] wr_addr;
   entry_type     wr_data;

   // decide-step helpers
   logic [31:0]   age;
   logic          evict;
   logic          do_ev;
   logic          keep;
   logic [IW-1:0] tgt;
   logic          rsp_load;

   lttc_entry_ram #(
      .DEPTH (TABLE_DEPTH)
   ) u_ram (
      .clock   (clock),
      .rd_en   (issue_ff),
      .rd_addr (idx_ff),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tuser  = rsp_hit_ff;
   assign rsp_tdata  = {3'b000, rsp_used_ff, rsp_miss_ff, rsp_hits_ff, rsp_gval_ff};

   assign age      = op_now_ff - ment_ff.created;
   assign evict    = (MW'(count_ff) >= MW'(max_items_ff)) || (count_ff == CW'(TABLE_DEPTH));
   assign do_ev    = evict && vic_found_ff;
   assign keep     = found_ff && !(do_ev && (vic_ff == match_ff));
   assign rsp_load = (state_ff == ST_OUT) && (!rsp_tvalid_ff || rsp_tready);

   always_comb begin
      if (keep) begin
         tgt = match_ff;
      end else if (do_ev && (!free_found_ff || (vic_ff < free_ff))) begin
         tgt = vic_ff;
      end else begin
         tgt = free_ff;
      end
   end

   always_comb begin
      state_in      = state_ff;
      valid_in      = valid_ff;
      count_in      = count_ff;
      hit_cnt_in    = hit_cnt_ff;
      miss_cnt_in   = miss_cnt_ff;
      issue_in      = issue_ff;
      d_vld_in      = issue_ff;
      d_idx_in      = idx_ff;
      op_mode_in    = op_mode_ff;
      op_key_in     = op_key_ff;
      op_val_in     = op_val_ff;
      op_now_in     = op_now_ff;
      idx_in        = idx_ff;
      found_in      = found_ff;
      match_in      = match_ff;
      ment_in       = ment_ff;
      free_found_in = free_found_ff;
      free_in       = free_ff;
      vic_found_in  = vic_found_ff;
      vic_in        = vic_ff;
      vic_uses_in   = vic_uses_ff;
      vic_last_in   = vic_last_ff;
      res_hit_in    = res_hit_ff;
      res_gval_in   = res_gval_ff;
      wr_en         = 1'b0;
      wr_addr       = match_ff;
      wr_data       = ment_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               op_mode_in    = mode_type'(req_tuser);
               op_key_in     = req_tdata[63:0];
               op_val_in     = req_tdata[95:64];
               op_now_in     = req_tdata[127:96];
               res_hit_in    = 1'b0;
               res_gval_in   = 32'd0;
               found_in      = 1'b0;
               free_found_in = 1'b0;
               vic_found_in  = 1'b0;
               idx_in        = '0;
               if (mode_type'(req_tuser) == MODE_CLEAR) begin
                  valid_in    = '0;
                  count_in    = '0;
                  hit_cnt_in  = 32'd0;
                  miss_cnt_in = 32'd0;
                  state_in    = ST_OUT;
               end else begin
                  issue_in = 1'b1;
                  state_in = ST_SCAN;
               end
            end
         end

         ST_SCAN: begin
            // issue side: one slot read per clock
            if (issue_ff) begin
               idx_in = IW'(idx_ff + 1'b1);
               if (idx_ff == LAST_IDX) begin
                  issue_in = 1'b0;
               end
            end
            // return side: compare the slot read on the previous clock
            if (d_vld_ff) begin
               if (valid_ff[d_idx_ff] && (rd_data.key == op_key_ff) && !found_ff) begin
                  found_in = 1'b1;
                  match_in = d_idx_ff;
                  ment_in  = rd_data;
               end
               if (!valid_ff[d_idx_ff] && !free_found_ff) begin
                  free_found_in = 1'b1;
                  free_in       = d_idx_ff;
               end
               if (valid_ff[d_idx_ff] &&
                   (!vic_found_ff || (rd_data.uses < vic_uses_ff) ||
                    ((rd_data.uses == vic_uses_ff) && (rd_data.last_use < vic_last_ff)))) begin
                  vic_found_in = 1'b1;
                  vic_in       = d_idx_ff;
                  vic_uses_in  = rd_data.uses;
                  vic_last_in  = rd_data.last_use;
               end
               if (d_idx_ff == LAST_IDX) begin
                  state_in = ST_DECIDE;
               end
            end
         end

         ST_DECIDE: begin
            state_in = ST_OUT;
            case (op_mode_ff)
               MODE_GET: begin
                  if (!found_ff) begin
                     miss_cnt_in = sat_inc32(miss_cnt_ff);
                  end else if (age > ttl_ff) begin
                     // expired: drop the entry and count a miss
                     valid_in[match_ff] = 1'b0;
                     count_in           = CW'(count_ff - 1'b1);
                     miss_cnt_in        = sat_inc32(miss_cnt_ff);
                  end else begin
                     wr_en            = 1'b1;
                     wr_addr          = match_ff;
                     wr_data          = ment_ff;
                     wr_data.last_use = op_now_ff;
                     wr_data.uses     = sat_inc32(ment_ff.uses);
                     hit_cnt_in       = sat_inc32(hit_cnt_ff);
                     res_hit_in       = 1'b1;
                     res_gval_in      = ment_ff.value;
                  end
               end
               MODE_PUT: begin
                  if (do_ev) begin
                     valid_in[vic_ff] = 1'b0;
                  end
                  valid_in[tgt]    = 1'b1;
                  count_in         = CW'(count_ff - CW'(do_ev) + CW'(!keep));
                  wr_en            = 1'b1;
                  wr_addr          = tgt;
                  wr_data.key      = op_key_ff;
                  wr_data.value    = op_val_ff;
                  wr_data.created  = op_now_ff;
                  wr_data.last_use = op_now_ff;
                  wr_data.uses     = 32'd0;
               end
               MODE_REMOVE: begin
                  if (found_ff) begin
                     valid_in[match_ff] = 1'b0;
                     count_in           = CW'(count_ff - 1'b1);
                  end
               end
               default: ;
            endcase
         end

         ST_OUT: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   // result register
   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff;
      rsp_hit_in    = rsp_hit_ff;
      rsp_gval_in   = rsp_gval_ff;
      rsp_hits_in   = rsp_hits_ff;
      rsp_miss_in   = rsp_miss_ff;
      rsp_used_in   = rsp_used_ff;
      if (rsp_load) begin
         rsp_tvalid_in = 1'b1;
         rsp_hit_in    = res_hit_ff;
         rsp_gval_in   = res_gval_ff;
         rsp_hits_in   = hit_cnt_ff;
         rsp_miss_in   = miss_cnt_ff;
         rsp_used_in   = (MW'(count_ff) > MW'(5'd31)) ? 5'd31 : 5'(count_ff);
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         max_items_ff  <= MAX_ITEMS_RST;
         ttl_ff        <= TTL_TICKS_RST;
         valid_ff      <= '0;
         count_ff      <= '0;
         hit_cnt_ff    <= 32'd0;
         miss_cnt_ff   <= 32'd0;
         issue_ff      <= 1'b0;
         d_vld_ff      <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         valid_ff      <= valid_in;
         count_ff      <= count_in;
         hit_cnt_ff    <= hit_cnt_in;
         miss_cnt_ff   <= miss_cnt_in;
         issue_ff      <= issue_in;
         d_vld_ff      <= d_vld_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
         if (csr_valid) begin
            case (csr_index)
               CSR_MAX_ITEMS: max_items_ff <= csr_data[4:0];
               CSR_TTL_TICKS: ttl_ff       <= csr_data;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      op_mode_ff    <= op_mode_in;
      op_key_ff     <= op_key_in;
      op_val_ff     <= op_val_in;
      op_now_ff     <= op_now_in;
      idx_ff        <= idx_in;
      d_idx_ff      <= d_idx_in;
      found_ff      <= found_in;
      match_ff      <= match_in;
      ment_ff       <= ment_in;
      free_found_ff <= free_found_in;
      free_ff       <= free_in;
      vic_found_ff  <= vic_found_in;
      vic_ff        <= vic_in;
      vic_uses_ff   <= vic_uses_in;
      vic_last_ff   <= vic_last_in;
      res_hit_ff    <= res_hit_in;
      res_gval_ff   <= res_gval_in;
      rsp_hit_ff    <= rsp_hit_in;
      rsp_gval_ff   <= rsp_gval_in;
      rsp_hits_ff   <= rsp_hits_in;
      rsp_miss_ff   <= rsp_miss_in;
      rsp_used_ff   <= rsp_used_in;
   end

endmodule

// ===== rtl/lttc_entry_ram.sv =====
`timescale 1ns / 1ps
// Entry storage for the cache table: one write port, one registered read port.
// Depends on lttc_pkg (entry_type).
module lttc_entry_ram #(
   parameter int DEPTH = lttc_pkg::TABLE_DEPTH_DEF
) (
   input  logic                     clock,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output lttc_pkg::entry_type      rd_data,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  lttc_pkg::entry_type      wr_data
);
   import lttc_pkg::*;

   entry_type mem [DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
